FILE: rtl/cbtd_pkg.sv
// Shared types, constants and decode functions of the battery telemetry decoder.
package cbtd_pkg;

    localparam int PACK_TEMPS = 10;
    localparam int CELL_COUNT = 126;
    localparam int POLL_IDS   = 15;
    localparam int TEMP_BASE  = 6;
    localparam int CELL_BASE  = TEMP_BASE + PACK_TEMPS;
    localparam int NENTRIES   = CELL_BASE + CELL_COUNT;
    localparam int QDEPTH     = 4;

    localparam logic [10:0] ID_AMBIENT = 11'h245;
    localparam logic [10:0] ID_TEMPS   = 11'h43c;
    localparam logic [10:0] ID_CELLS   = 11'h43d;
    localparam logic [10:0] ID_VOLT    = 11'h444;
    localparam logic [10:0] ID_SOC     = 11'h447;
    localparam logic [10:0] ID_DIAG_RX = 11'h7ef;
    localparam logic [10:0] ID_DIAG_TX = 11'h7e7;
    localparam logic [63:0] FLOW_CTRL  = 64'h0000_0000_0005_0830;
    localparam logic [7:0]  FIRST_FRAME = 8'h10;
    localparam logic [7:0]  HOLD_RESET = 8'd10;

    typedef logic [7:0]         entry_idx_t;
    typedef logic signed [12:0] val_t;

    // One update or transmit job handed from the front end to the back end.
    typedef struct packed {
        logic       tx;
        logic       last;
        entry_idx_t idx;
        val_t       value;
        logic [63:0] txp;
        logic [31:0] now;
    } job_t;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DECIDE} be_state_t;

    function automatic logic [15:0] poll_id(input logic [3:0] pos);
        unique case (pos)
            4'd0:  poll_id = 16'h0005;
            4'd1:  poll_id = 16'h0008;
            4'd2:  poll_id = 16'h0009;
            4'd3:  poll_id = 16'h002f;
            4'd4:  poll_id = 16'h0031;
            4'd5:  poll_id = 16'h0032;
            4'd6:  poll_id = 16'h002b;
            4'd7:  poll_id = 16'h002d;
            4'd8:  poll_id = 16'h000a;
            4'd9:  poll_id = 16'h000e;
            4'd10: poll_id = 16'h000b;
            4'd11: poll_id = 16'h000f;
            4'd12: poll_id = 16'h0010;
            4'd13: poll_id = 16'h0011;
            4'd14: poll_id = 16'h0012;
            default: poll_id = 16'h0005;
        endcase
    endfunction

    function automatic val_t temp_of(input logic [7:0] b);
        temp_of = val_t'($signed({5'd0, b})) - val_t'(40);
    endfunction

    function automatic val_t w12_of(input logic [7:0] lo, input logic [7:0] hi);
        w12_of = val_t'({1'b0, hi[3:0], lo});
    endfunction

endpackage

FILE: rtl/cbtd_front.sv
// Front end: accepts items, classifies frames and expands them into jobs one per cycle while the queue takes them.
module cbtd_front import cbtd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_op,
    input  logic [10:0] in_id,
    input  logic [3:0]  in_len,
    input  logic [63:0] in_pay,
    input  logic [31:0] in_now,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);
    // Pending job list for the current item, up to six.
    job_t       list_reg [6];
    job_t       list_next [6];
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] pos_reg, pos_next;
    logic [3:0] poll_reg, poll_next;

    logic [7:0] b [8];
    logic [9:0] base;
    job_t       tmp;
    logic [15:0] pid;
    logic [15:0] dpid;

    always_comb begin
        for (int k = 0; k < 8; k++) b[k] = in_pay[8*k +: 8];
    end

    assign in_ready  = (pos_reg == cnt_reg);
    assign job_valid = (pos_reg != cnt_reg);
    assign job       = list_reg[pos_reg];

    always_comb begin
        for (int k = 0; k < 6; k++) list_next[k] = list_reg[k];
        cnt_next  = cnt_reg;
        pos_next  = pos_reg;
        poll_next = poll_reg;
        base = {2'b0, b[0]} + {1'b0, b[0], 1'b0};
        pid  = poll_id(poll_reg);
        dpid = {b[2], b[3]};
        tmp  = '0;
        tmp.now = in_now;
        if (job_valid && job_ready) pos_next = pos_reg + 3'd1;
        if (in_valid && in_ready) begin
            pos_next = '0;
            cnt_next = '0;
            for (int k = 0; k < 6; k++) list_next[k] = tmp;
            if (in_op) begin
                list_next[0].tx  = 1'b1;
                list_next[0].txp = {32'd0, pid[7:0], pid[15:8], 16'h2203};
                cnt_next = 3'd1;
                poll_next = (poll_reg >= 4'(POLL_IDS - 1)) ? 4'd0 : poll_reg + 4'd1;
            end else if (in_len == 4'd8) begin
                unique case (in_id)
                    ID_AMBIENT: if (b[0] == 8'd1) begin
                        list_next[0].value = temp_of(b[4]);
                        cnt_next = 3'd1;
                    end
                    ID_TEMPS: begin
                        if (b[0] == 8'd0) begin
                            for (int k = 0; k < 6; k++) begin
                                list_next[k].idx = entry_idx_t'(TEMP_BASE + k);
                                list_next[k].value = temp_of(b[1+k]);
                            end
                            cnt_next = 3'd6;
                        end else if (b[0] == 8'd1) begin
                            for (int k = 0; k < 4; k++) begin
                                list_next[k].idx = entry_idx_t'(TEMP_BASE + 6 + k);
                                list_next[k].value = temp_of(b[1+k]);
                            end
                            cnt_next = 3'd4;
                        end
                    end
                    ID_CELLS: begin
                        for (int k = 0; k < 3; k++) begin
                            list_next[k].idx = 8'(base + 10'(CELL_BASE + k));
                            list_next[k].value = w12_of(b[1+2*k], b[2+2*k]);
                        end
                        if (base + 10'd2 < 10'(CELL_COUNT)) cnt_next = 3'd3;
                        else if (base + 10'd1 < 10'(CELL_COUNT)) cnt_next = 3'd2;
                        else if (base < 10'(CELL_COUNT)) cnt_next = 3'd1;
                    end
                    ID_VOLT: begin
                        list_next[0].idx = 8'd4;
                        list_next[0].value = w12_of(b[0], b[1]);
                        cnt_next = 3'd1;
                    end
                    ID_SOC: begin
                        list_next[0].idx = 8'd5;
                        list_next[0].value = w12_of(b[4], b[5]);
                        cnt_next = 3'd1;
                    end
                    ID_DIAG_RX: begin
                        if (b[0] == FIRST_FRAME) begin
                            list_next[0].tx = 1'b1;
                            list_next[0].txp = FLOW_CTRL;
                            cnt_next = 3'd1;
                        end
                        if (dpid == 16'h002f || dpid == 16'h0031 || dpid == 16'h0032) begin
                            list_next[cnt_next].idx = (dpid == 16'h002f) ? 8'd1 :
                                                      (dpid == 16'h0031) ? 8'd2 : 8'd3;
                            list_next[cnt_next].value = temp_of(b[4]);
                            cnt_next = cnt_next + 3'd1;
                        end
                    end
                    default: ;
                endcase
            end
            if (cnt_next != 3'd0) list_next[cnt_next - 3'd1].last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pos_reg  <= '0;
            poll_reg <= '0;
        end else begin
            cnt_reg  <= cnt_next;
            pos_reg  <= pos_next;
            poll_reg <= poll_next;
        end
        for (int k = 0; k < 6; k++) list_reg[k] <= list_next[k];
    end
endmodule

FILE: rtl/cbtd_queue.sv
// Short job queue between the front end and the back end.
module cbtd_queue import cbtd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_job,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_job
);
    job_t       mem_reg [QDEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign wr_ready = (cnt_reg != 3'(QDEPTH));
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_job   = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= wp_reg + 2'd1;
            if (rd_valid && rd_ready) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr_valid && wr_ready) - 3'(rd_valid && rd_ready);
        end
        if (wr_valid && wr_ready) mem_reg[wp_reg] <= wr_job;
    end
endmodule

FILE: rtl/cbtd_back.sv
// Back end: entry table lookup, change and hold checks, and the result register.
module cbtd_back import cbtd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  hold,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        out_valid,
    input  logic        out_ready,
    output job_t        out_job,
    output logic        busy
);
    // Entry table memory: value and last emit time. Known bits in flip-flops.
    logic [44:0]   tab_mem [NENTRIES];
    logic [44:0]   rd_reg;
    logic [NENTRIES-1:0] known_reg;
    be_state_t     st_reg, st_next;
    job_t          cur_reg;
    job_t          res_reg;
    logic          res_valid_reg, res_valid_next;
    logic          wr_en;
    logic          emit;
    logic          known;
    logic [31:0]   tstamp;
    val_t          stored;

    assign out_valid = res_valid_reg;
    assign out_job   = res_reg;
    assign busy      = (st_reg != ST_IDLE);
    assign known     = known_reg[cur_reg.idx];
    assign stored    = known ? val_t'(rd_reg[44:32]) : '0;
    assign tstamp    = known ? rd_reg[31:0] : 32'd0;

    always_comb begin
        st_next = st_reg;
        job_ready = 1'b0;
        res_valid_next = res_valid_reg && !out_ready;
        wr_en = 1'b0;
        emit  = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) st_next = ST_READ;
            end
            ST_READ: begin
                if (cur_reg.tx) begin
                    if (!res_valid_next) begin
                        res_valid_next = 1'b1;
                        emit = 1'b1;
                        st_next = ST_IDLE;
                    end
                end else st_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (known && stored == cur_reg.value) begin
                    st_next = ST_IDLE;
                end else if (cur_reg.now - tstamp < {24'd0, hold}) begin
                    wr_en = 1'b1;
                    st_next = ST_IDLE;
                end else if (!res_valid_next) begin
                    wr_en = 1'b1;
                    emit = 1'b1;
                    res_valid_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            res_valid_reg <= 1'b0;
            known_reg <= '0;
        end else begin
            st_reg <= st_next;
            res_valid_reg <= res_valid_next;
            if (wr_en) known_reg[cur_reg.idx] <= 1'b1;
        end
        if (st_reg == ST_IDLE && job_valid) cur_reg <= job;
        if (emit) begin
            res_reg <= cur_reg;
            // A dropped result of the item would have been last; the front end marks it.
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && job_valid) rd_reg <= tab_mem[job.idx];
        if (wr_en) tab_mem[cur_reg.idx] <= {cur_reg.value, emit ? cur_reg.now : tstamp};
    end
endmodule

FILE: rtl/can_battery_telemetry_decoder_top.sv
// Top level of the CAN battery telemetry decoder.
//
//  Channel   | Direction | Contents
//  s_axis    | in        | tuser: operation; tdata: can_id, frame_len, payload, now_seconds
//  m_axis    | out       | tuser: kind; tdata: entry, value, tx_can_id, tx_payload; tlast
//  cfg       | in        | hold_seconds write
//
// A transaction is accepted only once the previous one has fully drained. The front end
// classifies it and hands up to six jobs to the queue, one per cycle while the queue has room.
// The back end steps through accept, table read and decide for an entry update, and
// through accept and table read, where it emits, for a frame to transmit; it takes the
// next job only after returning to idle.
// Reset clears the known bits of all 142 entries at once and the poll position.
// A stalled receiver holds the back end, which holds the queue and then the front end.
// The newest result is held back until the next result exists or no job is left, so
// tlast lands on the final result of each transaction.
module can_battery_telemetry_decoder_top import cbtd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,  // can_id, frame_len, payload, now_seconds
    input  logic         s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // entry, value, tx_can_id, tx_payload
    output logic         m_axis_tuser,  // kind
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data
);
    logic [7:0] hold_reg;
    logic fr_valid, fr_ready;
    logic fj_valid, fj_ready, qj_valid, qj_ready, be_busy;
    job_t fj, qj, rj;
    logic pend_valid_reg;
    job_t pend_reg;
    logic r_valid, r_ready;
    logic src_idle, blk_idle, out_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) hold_reg <= HOLD_RESET;
        else if (cfg_valid) hold_reg <= cfg_data;
    end

    // No more results can appear once the front end, the queue and the back end are empty.
    assign src_idle = fr_ready && !qj_valid && !be_busy;
    // A new transaction waits until every result of the previous one has left.
    assign blk_idle = src_idle && !r_valid && !pend_valid_reg;
    assign fr_valid = s_axis_tvalid && blk_idle;
    assign s_axis_tready = fr_ready && blk_idle;

    cbtd_front u_front (
        .aclk, .aresetn,
        .in_valid(fr_valid), .in_ready(fr_ready),
        .in_op(s_axis_tuser), .in_id(s_axis_tdata[10:0]), .in_len(s_axis_tdata[14:11]),
        .in_pay(s_axis_tdata[78:15]), .in_now(s_axis_tdata[110:79]),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    cbtd_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
        .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_job(qj)
    );

    cbtd_back u_back (
        .aclk, .aresetn, .hold(hold_reg),
        .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
        .out_valid(r_valid), .out_ready(r_ready), .out_job(rj), .busy(be_busy)
    );

    // One-deep holding stage: a result is released once the next result exists, or once
    // no job is left, in which case it is the final result of its transaction.
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = pend_valid_reg && (r_valid || src_idle);
    assign r_ready = !pend_valid_reg || out_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) pend_valid_reg <= 1'b0;
        else if (r_valid && r_ready) pend_valid_reg <= 1'b1;
        else if (out_fire) pend_valid_reg <= 1'b0;
        if (r_valid && r_ready) pend_reg <= rj;
    end

    assign m_axis_tuser = pend_reg.tx;
    assign m_axis_tlast = pend_reg.last || !r_valid;
    assign m_axis_tdata = pend_reg.tx ?
        {pend_reg.txp, ID_DIAG_TX, 13'd0, 8'd0} :
        {64'd0, 11'd0, pend_reg.value, pend_reg.idx};
endmodule

FILE: sim/cbtd_checker.sv
// Scoreboard for the battery telemetry decoder: predicts results from accepted inputs and checks them.
module cbtd_checker import cbtd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         m_axis_tlast,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        kind;
        logic [7:0]  entry;
        logic [12:0] value;
        logic [10:0] txid;
        logic [63:0] txp;
        logic        last;
    } telem_result_t;

    localparam logic [15:0] DIAG_IDS [15] = '{
        16'h0005, 16'h0008, 16'h0009, 16'h002f, 16'h0031, 16'h0032, 16'h002b, 16'h002d,
        16'h000a, 16'h000e, 16'h000b, 16'h000f, 16'h0010, 16'h0011, 16'h0012
    };

    telem_result_t expected_results[$];
    logic [12:0]   table_value [NENTRIES];
    bit            table_known [NENTRIES];
    logic [31:0]   table_sent  [NENTRIES];
    int            poll_slot;
    logic [7:0]    hold;

    function automatic logic [7:0] byte_at(logic [63:0] p, int k);
        return p[8*k +: 8];
    endfunction

    function automatic logic [12:0] temp_at(logic [63:0] p, int k);
        return 13'({5'd0, p[8*k +: 8]}) - 13'd40;
    endfunction

    function automatic logic [12:0] word_at(logic [63:0] p, int k);
        return {1'b0, p[8*k+11 -: 4], p[8*k +: 8]};
    endfunction

    task automatic push_result(logic kind, logic [7:0] ent, logic [12:0] v,
                               logic [10:0] id, logic [63:0] data);
        telem_result_t r;
        r.kind = kind; r.entry = ent; r.value = v; r.txid = id; r.txp = data; r.last = 1'b0;
        expected_results.push_back(r);
    endtask

    // Store a changed value and emit it when the hold interval has run out.
    task automatic store_entry(int idx, logic [12:0] v, logic [31:0] now);
        if (table_known[idx] && table_value[idx] == v) return;
        table_value[idx] = v;
        table_known[idx] = 1'b1;
        if (32'(now - table_sent[idx]) < {24'd0, hold}) return;
        table_sent[idx] = now;
        push_result(1'b0, 8'(idx), v, 11'd0, 64'd0);
    endtask

    task automatic predict_item(logic op, logic [111:0] d);
        logic [10:0] id;
        logic [3:0]  len;
        logic [63:0] p;
        logic [31:0] now;
        logic [15:0] pid;
        int          count_before;
        int          cell_base;
        id  = d[10:0];
        len = d[14:11];
        p   = d[78:15];
        now = d[110:79];
        count_before = expected_results.size();
        if (op) begin
            pid = DIAG_IDS[poll_slot];
            push_result(1'b1, 8'd0, 13'd0, ID_DIAG_TX,
                        {32'd0, pid[7:0], pid[15:8], 8'h22, 8'h03});
            poll_slot = (poll_slot + 1) % POLL_IDS;
        end else if (len == 4'd8) begin
            case (id)
                ID_AMBIENT: if (byte_at(p, 0) == 8'd1) store_entry(0, temp_at(p, 4), now);
                ID_TEMPS: begin
                    if (byte_at(p, 0) == 8'd0)
                        for (int i = 0; i < 6; i++) store_entry(TEMP_BASE + i, temp_at(p, 1 + i), now);
                    else if (byte_at(p, 0) == 8'd1)
                        for (int i = 0; i < 4; i++) store_entry(TEMP_BASE + 6 + i, temp_at(p, 1 + i), now);
                end
                ID_CELLS: begin
                    cell_base = int'(byte_at(p, 0)) * 3;
                    for (int i = 0; i < 3; i++)
                        if (cell_base + i < CELL_COUNT)
                            store_entry(CELL_BASE + cell_base + i, word_at(p, 1 + 2 * i), now);
                end
                ID_VOLT: store_entry(4, word_at(p, 0), now);
                ID_SOC:  store_entry(5, word_at(p, 4), now);
                ID_DIAG_RX: begin
                    pid = {byte_at(p, 2), byte_at(p, 3)};
                    if (byte_at(p, 0) == FIRST_FRAME)
                        push_result(1'b1, 8'd0, 13'd0, ID_DIAG_TX, FLOW_CTRL);
                    if (pid == 16'h002f)      store_entry(1, temp_at(p, 4), now);
                    else if (pid == 16'h0031) store_entry(2, temp_at(p, 4), now);
                    else if (pid == 16'h0032) store_entry(3, temp_at(p, 4), now);
                end
                default: ;
            endcase
        end
        if (expected_results.size() > count_before)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    task automatic compare_result();
        telem_result_t e;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d entry %0d", m_axis_tuser, m_axis_tdata[7:0]);
            errors++;
            return;
        end
        e = expected_results.pop_front();
        if (m_axis_tuser !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, m_axis_tuser); errors++;
        end
        if (m_axis_tdata[7:0] !== e.entry) begin
            $error("entry: expected %0d, got %0d", e.entry, m_axis_tdata[7:0]); errors++;
        end
        if (m_axis_tdata[20:8] !== e.value) begin
            $error("value: expected %0d, got %0d", $signed(e.value),
                   $signed(m_axis_tdata[20:8])); errors++;
        end
        if (m_axis_tdata[31:21] !== e.txid) begin
            $error("tx_can_id: expected %h, got %h", e.txid, m_axis_tdata[31:21]); errors++;
        end
        if (m_axis_tdata[95:32] !== e.txp) begin
            $error("tx_payload: expected %h, got %h", e.txp, m_axis_tdata[95:32]); errors++;
        end
        if (m_axis_tlast !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, m_axis_tlast); errors++;
        end
    endtask

    initial begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_results.delete();
            for (int i = 0; i < NENTRIES; i++) begin
                table_value[i] = '0;
                table_known[i] = 1'b0;
                table_sent[i]  = '0;
            end
            poll_slot = 0;
            hold = HOLD_RESET;
        end else begin
            if (cfg_valid && cfg_ready) hold = cfg_data;
            if (m_axis_tvalid && m_axis_tready) compare_result();
            if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
        end
        pending = expected_results.size();
    end
endmodule

FILE: sim/testbench.sv
// Top of the battery telemetry decoder testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cbtd_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;   // can_id, frame_len, payload, now_seconds
    logic         s_axis_tuser;   // operation
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;   // entry, value, tx_can_id, tx_payload
    logic         m_axis_tuser;   // kind
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_data;
    int           errors;
    int           pending;

    // The running clock of the simulated vehicle; it advances slowly so the
    // hold interval both blocks and releases updates.
    logic [31:0]  clock_seconds;
    int           burst_left;
    int           idle_cycles;

    can_battery_telemetry_decoder_top i_dut (.*);

    cbtd_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver cycles through stretches of full readiness, random
    // back-pressure and long stalls so that stalls land on every phase.
    int ready_phase;
    always @(posedge aclk) begin
        ready_phase <= ready_phase + 1;
        case ((ready_phase / 97) % 3)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 99) < 60);
            default: m_axis_tready <= ((ready_phase % 23) > 15);
        endcase
    end

    // The watchdog ends the run when no transaction happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Present one input transaction and hold it until the decoder accepts it.
    // The sender runs in bursts separated by random gaps.
    task automatic send_item(logic op, logic [10:0] id, logic [3:0] len, logic [63:0] p,
                             logic [31:0] now);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, now, p, len, id};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_frame(logic [10:0] id, logic [63:0] p);
        send_item(1'b0, id, 4'd8, p, clock_seconds);
    endtask

    // Write the hold interval once the decoder has drained all results. A
    // frame whose updates are all suppressed may still be in the back end, so
    // the task keeps waiting before the write.
    task automatic write_hold(logic [7:0] seconds);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= seconds;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Bytes come mostly from a small pool so that repeated values occur.
    function automatic logic [7:0] pick_byte();
        logic [7:0] pool [4] = '{8'd0, 8'd40, 8'd65, 8'hff};
        return $urandom_range(0, 2) == 0 ? 8'($urandom) : pool[$urandom_range(0, 3)];
    endfunction

    function automatic logic [63:0] pick_payload(logic [7:0] b0);
        logic [63:0] p;
        p[7:0] = b0;
        for (int k = 1; k < 8; k++) p[8*k +: 8] = pick_byte();
        return p;
    endfunction

    // One random transaction: mostly well-formed frames for known
    // identifiers with random content, some poll ticks, and some noise.
    task automatic send_random();
        logic [10:0] ids [6] = '{ID_AMBIENT, ID_TEMPS, ID_CELLS, ID_VOLT, ID_SOC, ID_DIAG_RX};
        logic [63:0] p;
        logic [7:0]  b0;
        int          sel;
        int          roll;
        int          step;
        step = $urandom_range(0, 20);
        if ($urandom_range(0, 49) == 0) clock_seconds = $urandom;
        else clock_seconds = clock_seconds + step[4:0];
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            send_item(1'b1, 11'($urandom), 4'($urandom), {$urandom, $urandom}, clock_seconds);
        end else if (roll < 27) begin
            send_item(1'b0, 11'($urandom), 4'($urandom), {$urandom, $urandom}, $urandom);
        end else begin
            sel = $urandom_range(0, 5);
            case (sel)
                0: b0 = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'd1;
                1: b0 = $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 1));
                2: b0 = $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 43));
                5: b0 = $urandom_range(0, 1) == 0 ? FIRST_FRAME : 8'($urandom);
                default: b0 = 8'($urandom);
            endcase
            p = pick_payload(b0);
            if (sel == 5 && $urandom_range(0, 3) != 0)
                p[31:16] = {8'($urandom_range(0, 2) + 8'h31 - (($urandom_range(0, 2) == 0) ? 8'h2 : 8'h0)),
                            8'h00};
            send_frame(ids[sel], p);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        ready_phase   = 0;
        idle_cycles   = 0;
        burst_left    = 0;
        clock_seconds = 32'd100;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset hold interval: field extremes, every
        // identifier and selector, repeats, wrong lengths and poll ticks.
        send_item(1'b1, 11'h7ff, 4'hf, '1, 32'd0);
        send_item(1'b1, 11'h000, 4'h0, '0, 32'd0);
        send_frame(ID_AMBIENT, 64'h0000_00ff_0000_0001);
        send_frame(ID_AMBIENT, 64'h0000_00ff_0000_0001);
        send_frame(ID_AMBIENT, 64'h0000_0000_0000_0000);
        send_frame(ID_TEMPS, 64'hff00_ff00_1234_5600);
        send_frame(ID_TEMPS, 64'h0000_0000_ff00_2801);
        send_frame(ID_TEMPS, 64'h1111_1111_1111_1102);
        send_frame(ID_CELLS, 64'hffff_ffff_ffff_ff00);
        send_frame(ID_CELLS, 64'h0000_0fff_0123_4529);
        send_frame(ID_CELLS, 64'h1111_2222_3333_442a);
        send_frame(ID_CELLS, 64'h1111_2222_3333_44ff);
        send_frame(ID_VOLT, 64'hffff_ffff_ffff_ffff);
        send_frame(ID_SOC, 64'h0000_0abc_0000_0000);
        send_frame(ID_DIAG_RX, 64'h0000_0050_2f00_0010);
        send_frame(ID_DIAG_RX, 64'h0000_00ff_3100_0021);
        send_frame(ID_DIAG_RX, 64'h0000_0000_3200_0010);
        send_frame(ID_DIAG_RX, 64'h0000_0011_3300_0000);
        send_item(1'b0, ID_VOLT, 4'd7, 64'h0000_0000_0000_0123, clock_seconds);
        send_item(1'b0, ID_VOLT, 4'd0, 64'h0000_0000_0000_0456, clock_seconds);
        send_frame(11'h000, '1);
        send_frame(11'h7ff, '1);
        // Time wraps past the top of the 32-bit range.
        send_item(1'b0, ID_VOLT, 4'd8, 64'h0000_0000_0000_0777, 32'hffff_fffa);
        send_item(1'b0, ID_VOLT, 4'd8, 64'h0000_0000_0000_0778, 32'h0000_0010);

        write_hold(8'd0);
        repeat (60) send_random();
        write_hold(8'd255);
        repeat (55) send_random();
        write_hold(8'($urandom_range(1, 254)));
        repeat (65) send_random();
        write_hold(8'd3);
        repeat (65) send_random();

        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: can_battery_telemetry_decoder_top.f
rtl/cbtd_pkg.sv
rtl/cbtd_front.sv
rtl/cbtd_queue.sv
rtl/cbtd_back.sv
rtl/can_battery_telemetry_decoder_top.sv
sim/cbtd_checker.sv
sim/testbench.sv
